// ===== rtl/wbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Write buffer FIFO package
// Operation codes, result codes and the command record shared by the front
// and back parts of the write buffer.
// ----------------------------------------------------------------------------
package wbf_pkg;

   localparam int FUNC_W      = 3;
   localparam int KIND_W      = 3;
   localparam int BLK_W       = 20;
   localparam int OFF_W       = 4;
   localparam int DATA_W      = 64;
   localparam int HIT_W       = 3;
   localparam int HELD_W      = 4;
   localparam int BLOCK_BYTES = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_STORE = 3'd0,
      FUNC_EVICT = 3'd1,
      FUNC_DRAIN = 3'd2,
      FUNC_PROBE = 3'd3,
      FUNC_FLUSH = 3'd4
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED = 3'd0,
      KIND_REJECTED = 3'd1,
      KIND_DRAINED  = 3'd2,
      KIND_EMPTY    = 3'd3,
      KIND_HIT      = 3'd4,
      KIND_MISS     = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      OP_ENQ,
      OP_REJECT,
      OP_DRAIN,
      OP_PROBE,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               is_eviction;
      logic [BLK_W-1:0]   block;
      logic [OFF_W-1:0]   offset;
      logic [DATA_W-1:0]  data_low;
      logic [DATA_W-1:0]  data_high;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FULL_DRAIN,
      ST_FLUSH
   } state_type;

endpackage

// ===== rtl/write_buffer_fifo.sv =====
// ----------------------------------------------------------------------------
// Write buffer FIFO
// FIFO of block-sized store and eviction entries with drain, probe and flush.
//
//   channel   ports                 handshake
//   request   req_*                 start high while busy low
//   result    rsp_*                 rsp_valid strobe, one cycle, no stall
//
// Each result beat is registered and appears the cycle after the back end
// makes it; a command stays queued until its last beat. Enqueue into a full
// buffer first drains the oldest entry, and flush drains every held entry. A
// two-entry command queue sets busy. Synchronous reset empties the buffer.
// ----------------------------------------------------------------------------
module write_buffer_fifo
   import wbf_pkg::*;
#(
   parameter int ENTRIES     = 8,
   parameter int STORE_BYTES = 4,
   parameter int ADDR_BITS   = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [23:0]          req_address,
   input  logic [DATA_W-1:0]    req_data_low,
   input  logic [DATA_W-1:0]    req_data_high,
   output logic                 rsp_valid,
   output logic [KIND_W-1:0]    rsp_result_kind,
   output logic                 rsp_last,
   output logic                 rsp_entry_is_eviction,
   output logic [BLK_W-1:0]     rsp_entry_block,
   output logic [OFF_W-1:0]     rsp_entry_offset,
   output logic [DATA_W-1:0]    rsp_entry_data_low,
   output logic [DATA_W-1:0]    rsp_entry_data_high,
   output logic [HIT_W-1:0]     rsp_hit_index,
   output logic [HELD_W-1:0]    rsp_entries_held
);

   logic    q_full, q_empty, q_pop;
   cmd_type q_cmd;
   logic    drn_ev;
   logic [BLK_W-1:0]  drn_blk;
   logic [OFF_W-1:0]  drn_off;
   logic [DATA_W-1:0] drn_lo, drn_hi;

   assign busy = q_full;

   wbf_front #(.STORE_BYTES(STORE_BYTES), .ADDR_BITS(ADDR_BITS)) u_front (
      .clock, .reset,
      .req_valid(start), .req_func, .req_address, .req_data_low, .req_data_high,
      .q_full, .q_empty, .q_cmd, .q_pop
   );

   wbf_back #(.ENTRIES(ENTRIES)) u_back (
      .clock, .reset, .q_empty, .q_cmd, .q_pop,
      .rsp_valid, .rsp_result_kind, .rsp_last,
      .rsp_entry_is_eviction(drn_ev), .rsp_entry_block(drn_blk),
      .rsp_entry_offset(drn_off), .rsp_entry_data_low(drn_lo),
      .rsp_entry_data_high(drn_hi),
      .rsp_hit_index, .rsp_entries_held
   );

   wire is_drn = rsp_result_kind == KIND_DRAINED;

   assign rsp_entry_is_eviction = is_drn & drn_ev;
   assign rsp_entry_block       = is_drn ? drn_blk : '0;
   assign rsp_entry_offset      = is_drn ? drn_off : '0;
   assign rsp_entry_data_low    = is_drn ? drn_lo  : '0;
   assign rsp_entry_data_high   = is_drn ? drn_hi  : '0;

endmodule

// ===== rtl/wbf_front.sv =====
// ----------------------------------------------------------------------------
// Write buffer front end
// Classify a request beat, place store bytes in a block and hold the decoded
// command in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wbf_front
   import wbf_pkg::*;
#(
   parameter int STORE_BYTES = 4,
   parameter int ADDR_BITS   = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [23:0]          req_address,
   input  logic [DATA_W-1:0]    req_data_low,
   input  logic [DATA_W-1:0]    req_data_high,
   output logic                 q_full,
   output logic                 q_empty,
   output cmd_type              q_cmd,
   input  logic                 q_pop
);

   localparam int USE_BITS = (ADDR_BITS < 24) ? ADDR_BITS : 24;

   cmd_type           q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   cmd_type           cmd;
   logic [23:0]       addr_m;
   logic [127:0]      shifted;
   logic [127:0]      store_bits;
   logic [4:0]        end_pos;

   always_comb begin
      addr_m     = req_address & ((24'd1 << USE_BITS) - 24'd1);
      if (USE_BITS == 24) addr_m = req_address;
      store_bits = {64'd0, req_data_low & ((64'd1 << (8*STORE_BYTES)) - 64'd1)};
      if (STORE_BYTES == 8) store_bits = {64'd0, req_data_low};
      shifted    = store_bits << {addr_m[OFF_W-1:0], 3'd0};
      end_pos    = {1'b0, addr_m[OFF_W-1:0]} + 5'(STORE_BYTES);
      cmd             = '0;
      cmd.block       = addr_m[OFF_W +: BLK_W];
      cmd.offset      = addr_m[OFF_W-1:0];
      unique case (req_func)
         FUNC_STORE: begin
            if (end_pos > 5'(BLOCK_BYTES)) begin
               cmd.op = OP_REJECT;
            end else begin
               cmd.op        = OP_ENQ;
               cmd.data_low  = shifted[63:0];
               cmd.data_high = shifted[127:64];
            end
         end
         FUNC_EVICT: begin
            cmd.op          = OP_ENQ;
            cmd.is_eviction = 1'b1;
            cmd.offset      = '0;
            cmd.data_low    = req_data_low;
            cmd.data_high   = req_data_high;
         end
         FUNC_DRAIN: cmd.op = OP_DRAIN;
         FUNC_PROBE: cmd.op = OP_PROBE;
         FUNC_FLUSH: cmd.op = OP_FLUSH;
         default:    cmd.op = OP_REJECT;
      endcase
   end

   wire push = req_valid && !q_full;
   wire pop  = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cmd;
   end

   assign q_full  = cnt_ff == 2'd2;
   assign q_empty = cnt_ff == 2'd0;
   assign q_cmd   = q_ff[rd_ptr_ff];

   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");
   a_ptr_sync: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("queue count failed to advance");

endmodule

// ===== rtl/wbf_back.sv =====
// ----------------------------------------------------------------------------
// Write buffer back end
// Carry out queued commands on the slot array and emit result beats.
// ----------------------------------------------------------------------------
module wbf_back
   import wbf_pkg::*;
#(
   parameter int ENTRIES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  cmd_type              q_cmd,
   output logic                 q_pop,
   output logic                 rsp_valid,
   output logic [KIND_W-1:0]    rsp_result_kind,
   output logic                 rsp_last,
   output logic                 rsp_entry_is_eviction,
   output logic [BLK_W-1:0]     rsp_entry_block,
   output logic [OFF_W-1:0]     rsp_entry_offset,
   output logic [DATA_W-1:0]    rsp_entry_data_low,
   output logic [DATA_W-1:0]    rsp_entry_data_high,
   output logic [HIT_W-1:0]     rsp_hit_index,
   output logic [HELD_W-1:0]    rsp_entries_held
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int SUM_W = CNT_W + 1;

   logic                s_ev_ff   [ENTRIES];
   logic [BLK_W-1:0]    s_blk_ff  [ENTRIES];
   logic [OFF_W-1:0]    s_off_ff  [ENTRIES];
   logic [DATA_W-1:0]   s_lo_ff   [ENTRIES];
   logic [DATA_W-1:0]   s_hi_ff   [ENTRIES];
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    tail;
   logic [SUM_W-1:0]    tail_sum;
   logic [IDX_W-1:0]    head_nx;
   logic                full;
   logic                do_write;

   logic                r_valid_ff, r_valid_in;
   logic [KIND_W-1:0]   r_kind_ff, r_kind_in;
   logic                r_last_ff, r_last_in;
   logic [HIT_W-1:0]    r_hit_ff, r_hit_in;

   logic                probe_hit;
   logic [IDX_W-1:0]    probe_pos;
   logic [IDX_W-1:0]    rel;
   logic [SUM_W-1:0]    rel_sum;

   always_comb begin
      full     = occ_ff == CNT_W'(ENTRIES);
      tail_sum = SUM_W'(head_ff) + SUM_W'(occ_ff);
      if (tail_sum >= SUM_W'(ENTRIES)) tail_sum = tail_sum - SUM_W'(ENTRIES);
      tail     = IDX_W'(tail_sum);
      if (head_ff == IDX_W'(ENTRIES - 1)) head_nx = '0;
      else                               head_nx = head_ff + IDX_W'(1);
   end

   always_comb begin
      probe_hit = 1'b0;
      probe_pos = '0;
      rel_sum   = '0;
      rel       = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         rel_sum = SUM_W'(head_ff) + SUM_W'(i);
         if (rel_sum >= SUM_W'(ENTRIES)) rel_sum = rel_sum - SUM_W'(ENTRIES);
         rel = IDX_W'(rel_sum);
         if (CNT_W'(i) < occ_ff && s_blk_ff[rel] == q_cmd.block) begin
            probe_hit = 1'b1;
            probe_pos = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_cmd.op == OP_ENQ && full) state_in = ST_FULL_DRAIN;
               else if (q_cmd.op == OP_FLUSH && occ_ff > CNT_W'(1))
                  state_in = ST_FLUSH;
            end
         end
         ST_FULL_DRAIN: state_in = ST_IDLE;
         ST_FLUSH: if (occ_ff == CNT_W'(1)) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      head_in    = head_ff;
      occ_in     = occ_ff;
      q_pop      = 1'b0;
      do_write   = 1'b0;
      r_valid_in = 1'b0;
      r_kind_in  = KIND_REJECTED;
      r_last_in  = 1'b1;
      r_hit_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               r_valid_in = 1'b1;
               unique case (q_cmd.op)
                  OP_ENQ: begin
                     if (full) begin
                        r_kind_in  = KIND_DRAINED;
                        r_last_in  = 1'b0;
                        head_in    = head_nx;
                        occ_in     = occ_ff - CNT_W'(1);
                     end else begin
                        q_pop     = 1'b1;
                        do_write  = 1'b1;
                        r_kind_in = KIND_ACCEPTED;
                        occ_in    = occ_ff + CNT_W'(1);
                     end
                  end
                  OP_DRAIN, OP_FLUSH: begin
                     if (occ_ff == '0) begin
                        q_pop     = 1'b1;
                        r_kind_in = KIND_EMPTY;
                     end else begin
                        r_kind_in  = KIND_DRAINED;
                        head_in    = head_nx;
                        occ_in     = occ_ff - CNT_W'(1);
                        r_last_in  = (q_cmd.op == OP_DRAIN) || (occ_ff == CNT_W'(1));
                        q_pop      = r_last_in;
                     end
                  end
                  OP_PROBE: begin
                     q_pop     = 1'b1;
                     r_kind_in = probe_hit ? KIND_HIT : KIND_MISS;
                     r_hit_in  = probe_hit ? HIT_W'(probe_pos) : '0;
                  end
                  default: begin
                     q_pop     = 1'b1;
                     r_kind_in = KIND_REJECTED;
                  end
               endcase
            end
         end
         ST_FULL_DRAIN: begin
            q_pop      = 1'b1;
            do_write   = 1'b1;
            r_valid_in = 1'b1;
            r_kind_in  = KIND_ACCEPTED;
            occ_in     = occ_ff + CNT_W'(1);
         end
         ST_FLUSH: begin
            r_valid_in = 1'b1;
            r_kind_in  = KIND_DRAINED;
            head_in    = head_nx;
            occ_in     = occ_ff - CNT_W'(1);
            r_last_in  = occ_ff == CNT_W'(1);
            q_pop      = r_last_in;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         occ_ff     <= '0;
         r_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         occ_ff     <= occ_in;
         r_valid_ff <= r_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_kind_ff  <= r_kind_in;
      r_last_ff  <= r_last_in;
      r_hit_ff   <= r_hit_in;
      rsp_entry_is_eviction <= s_ev_ff[head_ff];
      rsp_entry_block       <= s_blk_ff[head_ff];
      rsp_entry_offset      <= s_off_ff[head_ff];
      rsp_entry_data_low    <= s_lo_ff[head_ff];
      rsp_entry_data_high   <= s_hi_ff[head_ff];
      if (do_write) begin
         s_ev_ff[tail]  <= q_cmd.is_eviction;
         s_blk_ff[tail] <= q_cmd.block;
         s_off_ff[tail] <= q_cmd.offset;
         s_lo_ff[tail]  <= q_cmd.data_low;
         s_hi_ff[tail]  <= q_cmd.data_high;
      end
   end

   logic [HELD_W-1:0] held_ff;
   always_ff @(posedge clock) held_ff <= HELD_W'(occ_in);

   assign rsp_valid        = r_valid_ff;
   assign rsp_result_kind  = r_kind_ff;
   assign rsp_last         = r_last_ff;
   assign rsp_hit_index    = r_hit_ff;
   assign rsp_entries_held = held_ff;

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(ENTRIES)) else $error("occupancy out of range");
   a_drain_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FULL_DRAIN) |=> (occ_ff == CNT_W'(ENTRIES)))
      else $error("full drain did not refill");
   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && occ_ff == CNT_W'(1)) |-> r_last_in)
      else $error("flush end not marked");

endmodule
